// ===== design/vte_pkg.sv =====
// Shared types and constants for the visited position table with expiry.
package vte_pkg;

    localparam int DATA_W = 32;
    localparam int DT_W   = 24;
    localparam int CMD_W  = 2;

    // Expiry limit after reset: 50.0 in Q16.16.
    localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd3276800;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_MARK  = 2'd1,
        CMD_CHECK = 2'd2,
        CMD_RESET = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TIME,
        S_SCAN,
        S_DONE
    } t_state;

    typedef enum logic {
        ALU_ADD,
        ALU_MATCH
    } t_alu_op;

    // Operands of the shared unit: ADD forms sat(a + b) and compares it against c,
    // MATCH compares the pair (a, b) against the pair (c, d).
    typedef struct packed {
        t_alu_op           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] c;
        logic [DATA_W-1:0] d;
    } t_alu_req;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic              flag;
    } t_alu_rsp;

    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] y;
        logic              visited;
        logic [DATA_W-1:0] age;
    } t_entry;

endpackage

// ===== design/vte_if.sv =====
// Request and response channel interfaces of the visited position table.
interface vte_req_if import vte_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic [DT_W-1:0]          delta_time;

    modport source (output valid, output command, output pos_x, output pos_y,
                    output delta_time, input ready);
    modport sink   (input valid, input command, input pos_x, input pos_y,
                    input delta_time, output ready);
endinterface

interface vte_rsp_if import vte_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              was_visited;
    logic              table_full;
    logic [DATA_W-1:0] elapsed_value;

    modport source (output valid, output was_visited, output table_full,
                    output elapsed_value, input ready);
    modport sink   (input valid, input was_visited, input table_full,
                    input elapsed_value, output ready);
endinterface

// ===== design/visited_table_with_expiry_core.sv =====
// Top level of the visited position table with expiry.
// A tick updates the timer and then scans every entry in use; mark and check stop at the
// first matching entry or else scan every entry in use, and a timer reset goes straight
// to the result. One request at a time; the scan reads one entry per cycle through the
// shared add/compare unit.
// Reset is synchronous: it empties the table, clears the timer and the response valid flag, and restores the limit.
module visited_table_with_expiry_core import vte_pkg::*; #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [DATA_W-1:0] i_cfg_wr_data,
    vte_req_if.sink           i_req,
    vte_rsp_if.source         o_rsp
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_DEPTH);

    t_state            r_state, n_state;
    logic [DATA_W-1:0] r_limit;
    logic [DATA_W-1:0] r_elapsed, n_elapsed;
    t_cmd              r_cmd;
    logic [DATA_W-1:0] r_x, r_y;
    logic [DT_W-1:0]   r_dt;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]  r_pidx, n_pidx;
    logic              r_pend, n_pend;
    logic              r_res_vis, n_res_vis;
    logic              r_res_full, n_res_full;
    logic              r_out_valid, n_out_valid;
    logic              r_out_vis, n_out_vis;
    logic              r_out_full, n_out_full;
    logic [DATA_W-1:0] r_out_elapsed, n_out_elapsed;

    t_cmd              w_req_cmd;
    logic              w_accept;
    logic              w_out_free;
    logic              w_lookup;
    logic              w_issue;
    logic              w_hit;
    logic              w_scan_end;
    t_alu_req          w_alu_req;
    t_alu_rsp          w_alu_rsp;
    logic              w_rd_en;
    logic [IDX_W-1:0]  w_rd_addr;
    t_entry            w_rd_data;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    t_entry            w_wr_data;

    // Handshake and scan status.
    assign w_req_cmd   = t_cmd'(i_req.command);
    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_lookup    = (r_cmd == CMD_MARK) || (r_cmd == CMD_CHECK);
    assign w_issue     = (r_state == S_SCAN) && (r_idx != r_fill);
    assign w_hit       = (r_state == S_SCAN) && r_pend && w_lookup && w_alu_rsp.flag;
    assign w_scan_end  = (r_state == S_SCAN) && (w_hit || (!r_pend && (r_idx == r_fill)));

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.was_visited   = r_out_vis;
    assign o_rsp.table_full    = r_out_full;
    assign o_rsp.elapsed_value = r_out_elapsed;

    vte_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    vte_store #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (w_req_cmd) inside
                        CMD_TICK:             n_state = S_TIME;
                        CMD_MARK, CMD_CHECK:  n_state = S_SCAN;
                        default:              n_state = S_DONE;
                    endcase
                end
            end
            S_TIME: n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: shared unit operands, memory access and register updates.
    always_comb begin
        n_elapsed     = r_elapsed;
        n_idx         = r_idx;
        n_fill        = r_fill;
        n_pidx        = r_pidx;
        n_pend        = r_pend;
        n_res_vis     = r_res_vis;
        n_res_full    = r_res_full;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_vis     = r_out_vis;
        n_out_full    = r_out_full;
        n_out_elapsed = r_out_elapsed;
        w_rd_en       = 1'b0;
        w_rd_addr     = r_idx[IDX_W-1:0];
        w_wr_en       = 1'b0;
        w_wr_addr     = r_pidx;
        w_wr_data     = w_rd_data;

        // Ticks add time to the entry age, lookups compare the stored position.
        w_alu_req.op = (w_lookup && (r_state == S_SCAN)) ? ALU_MATCH : ALU_ADD;
        w_alu_req.a  = (r_state == S_SCAN) ? (w_lookup ? w_rd_data.x : w_rd_data.age)
                                           : r_elapsed;
        w_alu_req.b  = (w_lookup && (r_state == S_SCAN)) ? w_rd_data.y : DATA_W'(r_dt);
        w_alu_req.c  = (r_state == S_SCAN && w_lookup) ? r_x : r_limit;
        w_alu_req.d  = r_y;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_res_vis  = 1'b0;
                    n_res_full = 1'b0;
                    if (w_req_cmd == CMD_RESET) begin
                        n_elapsed = '0;
                    end
                end
            end
            S_TIME: begin
                n_elapsed = w_alu_rsp.sum;
            end
            S_SCAN: begin
                w_rd_en = w_issue;
                n_idx   = w_issue ? (r_idx + 1'b1) : r_idx;
                n_pend  = w_issue && !w_scan_end;
                n_pidx  = r_idx[IDX_W-1:0];
                if (!w_lookup) begin
                    // Age a visited entry; past the limit it loses its mark.
                    if (r_pend && w_rd_data.visited) begin
                        w_wr_en           = 1'b1;
                        w_wr_data.visited = !w_alu_rsp.flag;
                        w_wr_data.age     = w_alu_rsp.flag ? '0 : w_alu_rsp.sum;
                    end
                end else if (w_hit) begin
                    if (r_cmd == CMD_MARK) begin
                        w_wr_en           = 1'b1;
                        w_wr_data.visited = 1'b1;
                    end else begin
                        n_res_vis = w_rd_data.visited;
                    end
                end else if (w_scan_end && (r_cmd == CMD_CHECK)) begin
                    // Miss: insert at the lowest free entry, or report a full table.
                    if (r_fill != FILL_MAX) begin
                        w_wr_en           = 1'b1;
                        w_wr_addr         = r_fill[IDX_W-1:0];
                        w_wr_data.x       = r_x;
                        w_wr_data.y       = r_y;
                        w_wr_data.visited = 1'b0;
                        w_wr_data.age     = '0;
                        n_fill            = r_fill + 1'b1;
                    end else begin
                        n_res_full = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_vis     = r_res_vis;
                    n_out_full    = r_res_full;
                    n_out_elapsed = r_elapsed;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_elapsed   <= '0;
            r_fill      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_elapsed   <= n_elapsed;
            r_fill      <= n_fill;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_req_cmd;
            r_x   <= i_req.pos_x;
            r_y   <= i_req.pos_y;
            r_dt  <= i_req.delta_time;
        end
        r_pidx        <= n_pidx;
        r_res_vis     <= n_res_vis;
        r_res_full    <= n_res_full;
        r_out_vis     <= n_out_vis;
        r_out_full    <= n_out_full;
        r_out_elapsed <= n_out_elapsed;
    end

endmodule

// ===== design/vte_alu.sv =====
// Shared saturating adder with limit compare and position match compare.
module vte_alu import vte_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [DATA_W:0]   w_sum;
    logic [DATA_W-1:0] w_sat;

    // Full-width sum, clamped to all ones on carry out.
    assign w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};
    assign w_sat = w_sum[DATA_W] ? {DATA_W{1'b1}} : w_sum[DATA_W-1:0];

    // The flag is the expiry test for adds and the hit test for matches.
    always_comb begin
        o_rsp.sum = w_sat;
        unique case (i_req.op)
            ALU_ADD:   o_rsp.flag = (w_sat > i_req.c);
            ALU_MATCH: o_rsp.flag = (i_req.a == i_req.c) && (i_req.b == i_req.d);
            default:   o_rsp.flag = 1'b0;
        endcase
    end

endmodule

// ===== design/vte_store.sv =====
// Entry memory: one write port and one registered read port.
module vte_store import vte_pkg::*; #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/vte_checker.sv =====
// Port-level checks of the visited position table, bound to the top level.
module vte_checker import vte_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic              i_rsp_was_visited,
    input logic              i_rsp_table_full,
    input logic [DATA_W-1:0] i_rsp_elapsed_value
);

    // A stalled response stays offered.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response keeps its timer value.
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_elapsed_value))
        else $error("response timer changed while stalled");

    // A full-table miss never reports a visited entry.
    a_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> !(i_rsp_was_visited && i_rsp_table_full))
        else $error("full table reported together with a visited hit");

    // The block works on one request at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while another is in progress");

endmodule

bind visited_table_with_expiry_core vte_checker u_vte_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_was_visited   (o_rsp.was_visited),
    .i_rsp_table_full    (o_rsp.table_full),
    .i_rsp_elapsed_value (o_rsp.elapsed_value)
);
